// ===== rtl/iems_pkg.sv =====
`default_nettype none
package iems_pkg;

	localparam int PAGE_BYTES     = 8;
	localparam int SEQ_READ_BYTES = 8;
	localparam int PB_IDX_W       = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
	localparam int BC_MAX         = (PAGE_BYTES > SEQ_READ_BYTES) ? PAGE_BYTES : SEQ_READ_BYTES;
	localparam int BC_W           = $clog2(BC_MAX + 1);
	localparam int WAIT_W         = 16;
	localparam int BIT_W          = 4;

	localparam logic [7:0] DEV_WRITE = 8'hA0;
	localparam logic [7:0] DEV_READ  = 8'hA1;

	localparam logic [1:0] REQ_TICK = 2'd0;
	localparam logic [1:0] REQ_LOAD = 2'd1;
	localparam logic [1:0] REQ_CMD  = 2'd2;

	localparam logic [2:0] OP_BYTE_WR = 3'd0;
	localparam logic [2:0] OP_PAGE_WR = 3'd1;
	localparam logic [2:0] OP_CUR_RD  = 3'd2;
	localparam logic [2:0] OP_RAND_RD = 3'd3;
	localparam logic [2:0] OP_SEQ_RD  = 3'd4;

	localparam logic [0:0] CFG_HALF = 1'b0;
	localparam logic [0:0] CFG_FULL = 1'b1;

	typedef struct packed {
		logic [1:0] req_type;
		logic [2:0] command_op;
		logic [7:0] mem_address;
		logic [7:0] data_byte;
		logic [2:0] buffer_slot;
		logic       sda_in;
	} in_word_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic       read_valid;
		logic [7:0] read_value;
		logic [2:0] read_position;
		logic       nack_error;
		logic       poll_seen;
	} out_word_t;

	typedef struct packed {
		logic [0:0]        reg_index;
		logic [WAIT_W-1:0] wdata;
	} cfg_word_t;

	typedef enum logic [17:0] {
		PH_IDLE     = 18'd1 << 0,
		PH_START_W  = 18'd1 << 1,
		PH_DEVW     = 18'd1 << 2,
		PH_DEVW_ACK = 18'd1 << 3,
		PH_POLL     = 18'd1 << 4,
		PH_ADDR     = 18'd1 << 5,
		PH_ADDR_ACK = 18'd1 << 6,
		PH_DATA     = 18'd1 << 7,
		PH_DATA_ACK = 18'd1 << 8,
		PH_PAGE     = 18'd1 << 9,
		PH_PAGE_ACK = 18'd1 << 10,
		PH_START_R  = 18'd1 << 11,
		PH_DEVR     = 18'd1 << 12,
		PH_DEVR_ACK = 18'd1 << 13,
		PH_READ     = 18'd1 << 14,
		PH_SACK     = 18'd1 << 15,
		PH_NOACK    = 18'd1 << 16,
		PH_STOP     = 18'd1 << 17
	} phase_t;

	// resume points after a line wait
	typedef enum logic [28:0] {
		S_START_SDA1 = 29'd1 << 0,
		S_START_SCL1 = 29'd1 << 1,
		S_START_SDA0 = 29'd1 << 2,
		S_START_SCL0 = 29'd1 << 3,
		S_START_END  = 29'd1 << 4,
		S_STOP_SCL0  = 29'd1 << 5,
		S_STOP_SDA0  = 29'd1 << 6,
		S_STOP_SCL1  = 29'd1 << 7,
		S_STOP_SDA1  = 29'd1 << 8,
		S_STOP_END   = 29'd1 << 9,
		S_SEND_BIT   = 29'd1 << 10,
		S_SEND_SCL1  = 29'd1 << 11,
		S_SEND_REP   = 29'd1 << 12,
		S_ACK_SCL1   = 29'd1 << 13,
		S_ACK_SAMP   = 29'd1 << 14,
		S_ACK_END    = 29'd1 << 15,
		S_NOACK_SDA1 = 29'd1 << 16,
		S_NOACK_SCL1 = 29'd1 << 17,
		S_NOACK_END  = 29'd1 << 18,
		S_SACK_SDA0  = 29'd1 << 19,
		S_SACK_SCL1  = 29'd1 << 20,
		S_SACK_END   = 29'd1 << 21,
		S_READ_LOOP  = 29'd1 << 22,
		S_READ_SCL1  = 29'd1 << 23,
		S_READ_SAMP  = 29'd1 << 24,
		S_READ_SCL0  = 29'd1 << 25,
		S_READ_REP   = 29'd1 << 26,
		S_READ_END   = 29'd1 << 27,
		S_PWAIT_END  = 29'd1 << 28
	} step_t;

endpackage
`default_nettype wire

// ===== rtl/iems_if.sv =====
`default_nettype none
interface iems_cmd_if;
	logic               valid;
	logic               ready;
	iems_pkg::in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface iems_res_if;
	logic                valid;
	logic                ready;
	iems_pkg::out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface iems_cfg_if;
	logic                valid;
	logic                ready;
	iems_pkg::cfg_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/i2c_eeprom_master_sequencer.sv =====
`default_nettype none
// channel | dir | word                           | accepted when
// cmd     | in  | tick, page load or command     | cmd.valid && cmd.ready
// res     | out | line levels, flags, read byte  | res.valid && res.ready
// cfg     | in  | half/full wait register write  | cfg.valid && cfg.ready
//
// One word per clock. Its result is in the two-entry output queue the next cycle.
// cmd.ready drops only while both queue entries are held by a stalled res.
// arst_n returns to idle with SCL high, SDA high and driven; cfg.ready is always high.
// The page buffer holds no reset value.
module i2c_eeprom_master_sequencer (
	input wire         clk,
	input wire         arst_n,
	iems_cmd_if.sink   cmd,
	iems_res_if.source res,
	iems_cfg_if.sink   cfg
);

	typedef enum logic [2:0] {
		PR_START, PR_STOP, PR_SEND, PR_ACK, PR_NOACK, PR_SACK, PR_READ, PR_PWAIT
	} prim_t;

	logic [iems_pkg::WAIT_W-1:0] half_q, full_q;
	iems_pkg::phase_t            phase_q, phase_n;
	iems_pkg::step_t             step_q, step_n;
	logic [iems_pkg::WAIT_W-1:0] wc_q, wc_n;
	logic [iems_pkg::BIT_W-1:0]  bit_q, bit_n;
	logic [iems_pkg::BC_W-1:0]   bc_q, bc_n, bc_inc;
	logic [7:0]                  shift_q, shift_n;
	logic [2:0]                  op_q, op_n;
	logic [7:0]                  addr_q, addr_n, data_q, data_n;
	logic                        scl_q, scl_n, sda_q, sda_n, drv_q, drv_n;
	logic                        nack_q, nack_n, poll_q, poll_n, lnack_q, lnack_n;
	logic [7:0]                  pb_q [iems_pkg::PAGE_BYTES];
	logic                        pb_we;
	logic [iems_pkg::PB_IDX_W-1:0] pb_wa;

	logic                        accept, busy, fire, end_hit, launch, wait_ld, wait_full;
	logic                        done, emit;
	prim_t                       prim;
	logic [iems_pkg::WAIT_W-1:0] half_eff, full_eff;
	iems_pkg::out_word_t         res_word;

	iems_pkg::out_word_t         fifo_q [2];
	logic                        wr_ptr_q, rd_ptr_q;
	logic [1:0]                  cnt_q;
	logic                        pop;

	assign cfg.ready = 1'b1;
	assign cmd.ready = (cnt_q != 2'd2);
	assign accept    = cmd.valid && cmd.ready;
	assign busy      = (phase_q != iems_pkg::PH_IDLE);
	assign half_eff  = (half_q == '0) ? iems_pkg::WAIT_W'(1) : half_q;
	assign full_eff  = (full_q == '0) ? iems_pkg::WAIT_W'(1) : full_q;
	assign bc_inc    = bc_q + iems_pkg::BC_W'(1);
	assign pb_we     = accept && (cmd.data.req_type == iems_pkg::REQ_LOAD)
		&& (int'(cmd.data.buffer_slot) < iems_pkg::PAGE_BYTES);
	assign pb_wa     = iems_pkg::PB_IDX_W'(cmd.data.buffer_slot);

	always_comb begin
		phase_n   = phase_q;
		step_n    = step_q;
		wc_n      = wc_q;
		bit_n     = bit_q;
		bc_n      = bc_q;
		shift_n   = shift_q;
		op_n      = op_q;
		addr_n    = addr_q;
		data_n    = data_q;
		scl_n     = scl_q;
		sda_n     = sda_q;
		drv_n     = drv_q;
		nack_n    = nack_q;
		poll_n    = poll_q;
		lnack_n   = lnack_q;
		fire      = 1'b0;
		end_hit   = 1'b0;
		launch    = 1'b0;
		prim      = PR_START;
		wait_ld   = 1'b0;
		wait_full = 1'b0;
		done      = 1'b0;
		emit      = 1'b0;

		if (accept && cmd.data.req_type == iems_pkg::REQ_TICK && busy) begin
			wc_n = (wc_q == '0) ? '0 : wc_q - iems_pkg::WAIT_W'(1);
			fire = (wc_n == '0);
		end
		if (accept && cmd.data.req_type == iems_pkg::REQ_CMD && !busy
			&& cmd.data.command_op <= iems_pkg::OP_SEQ_RD) begin
			op_n    = cmd.data.command_op;
			addr_n  = cmd.data.mem_address;
			data_n  = cmd.data.data_byte;
			bc_n    = '0;
			phase_n = (cmd.data.command_op == iems_pkg::OP_CUR_RD) ?
				iems_pkg::PH_START_R : iems_pkg::PH_START_W;
			launch  = 1'b1;
			prim    = PR_START;
		end

		if (fire) begin
			unique case (step_q)
				iems_pkg::S_START_SDA1: begin
					sda_n = 1'b1; wait_ld = 1'b1; step_n = iems_pkg::S_START_SCL1;
				end
				iems_pkg::S_START_SCL1: begin
					scl_n = 1'b1; wait_ld = 1'b1; wait_full = 1'b1;
					step_n = iems_pkg::S_START_SDA0;
				end
				iems_pkg::S_START_SDA0: begin
					sda_n = 1'b0; wait_ld = 1'b1; wait_full = 1'b1;
					step_n = iems_pkg::S_START_SCL0;
				end
				iems_pkg::S_START_SCL0: begin
					scl_n = 1'b0; wait_ld = 1'b1; wait_full = 1'b1;
					step_n = iems_pkg::S_START_END;
				end
				iems_pkg::S_STOP_SCL0: begin
					scl_n = 1'b0; wait_ld = 1'b1; step_n = iems_pkg::S_STOP_SDA0;
				end
				iems_pkg::S_STOP_SDA0: begin
					sda_n = 1'b0; wait_ld = 1'b1; wait_full = 1'b1;
					step_n = iems_pkg::S_STOP_SCL1;
				end
				iems_pkg::S_STOP_SCL1: begin
					scl_n = 1'b1; wait_ld = 1'b1; wait_full = 1'b1;
					step_n = iems_pkg::S_STOP_SDA1;
				end
				iems_pkg::S_STOP_SDA1: begin
					sda_n = 1'b1; wait_ld = 1'b1; wait_full = 1'b1;
					step_n = iems_pkg::S_STOP_END;
				end
				iems_pkg::S_SEND_BIT: begin
					sda_n   = shift_q[7];
					shift_n = {shift_q[6:0], 1'b0};
					wait_ld = 1'b1; step_n = iems_pkg::S_SEND_SCL1;
				end
				iems_pkg::S_SEND_SCL1: begin
					scl_n = 1'b1; wait_ld = 1'b1; wait_full = 1'b1;
					step_n = iems_pkg::S_SEND_REP;
				end
				iems_pkg::S_SEND_REP: begin
					bit_n = bit_q + iems_pkg::BIT_W'(1);
					scl_n = 1'b0;
					if (!bit_n[3]) begin
						wait_ld = 1'b1; step_n = iems_pkg::S_SEND_BIT;
					end else begin
						end_hit = 1'b1;
					end
				end
				iems_pkg::S_ACK_SCL1: begin
					scl_n = 1'b1; wait_ld = 1'b1; step_n = iems_pkg::S_ACK_SAMP;
				end
				iems_pkg::S_ACK_SAMP: begin
					lnack_n = cmd.data.sda_in; wait_ld = 1'b1; step_n = iems_pkg::S_ACK_END;
				end
				iems_pkg::S_ACK_END: begin
					scl_n = 1'b0; drv_n = 1'b1; sda_n = 1'b0; end_hit = 1'b1;
				end
				iems_pkg::S_NOACK_SDA1: begin
					sda_n = 1'b1; wait_ld = 1'b1; step_n = iems_pkg::S_NOACK_SCL1;
				end
				iems_pkg::S_NOACK_SCL1: begin
					scl_n = 1'b1; wait_ld = 1'b1; wait_full = 1'b1;
					step_n = iems_pkg::S_NOACK_END;
				end
				iems_pkg::S_NOACK_END: begin
					scl_n = 1'b0; sda_n = 1'b0; end_hit = 1'b1;
				end
				iems_pkg::S_SACK_SDA0: begin
					sda_n = 1'b0; wait_ld = 1'b1; step_n = iems_pkg::S_SACK_SCL1;
				end
				iems_pkg::S_SACK_SCL1: begin
					scl_n = 1'b1; wait_ld = 1'b1; wait_full = 1'b1;
					step_n = iems_pkg::S_SACK_END;
				end
				iems_pkg::S_SACK_END: begin
					scl_n = 1'b0; end_hit = 1'b1;
				end
				iems_pkg::S_READ_LOOP: begin
					bit_n = '0; wait_ld = 1'b1; step_n = iems_pkg::S_READ_SCL1;
				end
				iems_pkg::S_READ_SCL1: begin
					scl_n = 1'b1; wait_ld = 1'b1; step_n = iems_pkg::S_READ_SAMP;
				end
				iems_pkg::S_READ_SAMP: begin
					shift_n = {shift_q[6:0], cmd.data.sda_in};
					wait_ld = 1'b1; step_n = iems_pkg::S_READ_SCL0;
				end
				iems_pkg::S_READ_SCL0: begin
					scl_n = 1'b0; wait_ld = 1'b1; step_n = iems_pkg::S_READ_REP;
				end
				iems_pkg::S_READ_REP: begin
					bit_n   = bit_q + iems_pkg::BIT_W'(1);
					wait_ld = 1'b1;
					if (!bit_n[3]) begin
						step_n = iems_pkg::S_READ_SCL1;
					end else begin
						drv_n = 1'b1; sda_n = 1'b0; step_n = iems_pkg::S_READ_END;
					end
				end
				default: end_hit = 1'b1;
			endcase
		end

		if (end_hit) begin
			unique case (phase_q)
				iems_pkg::PH_START_W: begin
					shift_n = iems_pkg::DEV_WRITE; phase_n = iems_pkg::PH_DEVW;
					launch = 1'b1; prim = PR_SEND;
				end
				iems_pkg::PH_DEVW: begin
					phase_n = iems_pkg::PH_DEVW_ACK; launch = 1'b1; prim = PR_ACK;
				end
				iems_pkg::PH_DEVW_ACK: begin
					launch = 1'b1;
					if (lnack_q) begin
						poll_n = 1'b1; phase_n = iems_pkg::PH_POLL; prim = PR_PWAIT;
					end else begin
						shift_n = addr_q; phase_n = iems_pkg::PH_ADDR; prim = PR_SEND;
					end
				end
				iems_pkg::PH_POLL: begin
					phase_n = iems_pkg::PH_START_W; launch = 1'b1; prim = PR_START;
				end
				iems_pkg::PH_ADDR: begin
					phase_n = iems_pkg::PH_ADDR_ACK; launch = 1'b1; prim = PR_ACK;
				end
				iems_pkg::PH_ADDR_ACK: begin
					nack_n = nack_q | lnack_q;
					launch = 1'b1;
					if (op_q == iems_pkg::OP_BYTE_WR) begin
						shift_n = data_q; phase_n = iems_pkg::PH_DATA; prim = PR_SEND;
					end else if (op_q == iems_pkg::OP_PAGE_WR) begin
						bc_n = '0; shift_n = pb_q[0];
						phase_n = iems_pkg::PH_PAGE; prim = PR_SEND;
					end else begin
						phase_n = iems_pkg::PH_START_R; prim = PR_START;
					end
				end
				iems_pkg::PH_DATA: begin
					phase_n = iems_pkg::PH_DATA_ACK; launch = 1'b1; prim = PR_ACK;
				end
				iems_pkg::PH_DATA_ACK: begin
					nack_n = nack_q | lnack_q;
					phase_n = iems_pkg::PH_STOP; launch = 1'b1; prim = PR_STOP;
				end
				iems_pkg::PH_PAGE: begin
					phase_n = iems_pkg::PH_PAGE_ACK; launch = 1'b1; prim = PR_ACK;
				end
				iems_pkg::PH_PAGE_ACK: begin
					nack_n = nack_q | lnack_q;
					bc_n   = bc_inc;
					launch = 1'b1;
					if (bc_inc < iems_pkg::BC_W'(iems_pkg::PAGE_BYTES)) begin
						shift_n = pb_q[bc_inc[iems_pkg::PB_IDX_W-1:0]];
						phase_n = iems_pkg::PH_PAGE; prim = PR_SEND;
					end else begin
						phase_n = iems_pkg::PH_STOP; prim = PR_STOP;
					end
				end
				iems_pkg::PH_START_R: begin
					shift_n = iems_pkg::DEV_READ; phase_n = iems_pkg::PH_DEVR;
					launch = 1'b1; prim = PR_SEND;
				end
				iems_pkg::PH_DEVR: begin
					phase_n = iems_pkg::PH_DEVR_ACK; launch = 1'b1; prim = PR_ACK;
				end
				iems_pkg::PH_DEVR_ACK: begin
					nack_n = nack_q | lnack_q;
					bc_n = '0; phase_n = iems_pkg::PH_READ; launch = 1'b1; prim = PR_READ;
				end
				iems_pkg::PH_READ: begin
					emit   = 1'b1;
					launch = 1'b1;
					if (op_q == iems_pkg::OP_SEQ_RD
						&& bc_inc < iems_pkg::BC_W'(iems_pkg::SEQ_READ_BYTES)) begin
						phase_n = iems_pkg::PH_SACK; prim = PR_SACK;
					end else begin
						phase_n = iems_pkg::PH_NOACK; prim = PR_NOACK;
					end
				end
				iems_pkg::PH_SACK: begin
					bc_n = bc_inc; phase_n = iems_pkg::PH_READ; launch = 1'b1; prim = PR_READ;
				end
				iems_pkg::PH_NOACK: begin
					phase_n = iems_pkg::PH_STOP; launch = 1'b1; prim = PR_STOP;
				end
				default: begin
					phase_n = iems_pkg::PH_IDLE; done = 1'b1;
				end
			endcase
		end

		if (launch) begin
			wait_ld = 1'b1;
			unique case (prim)
				PR_START: begin
					nack_n = 1'b0; drv_n = 1'b1; wait_full = 1'b1;
					step_n = iems_pkg::S_START_SDA1;
				end
				PR_STOP: begin
					drv_n = 1'b1; wait_full = 1'b1; step_n = iems_pkg::S_STOP_SCL0;
				end
				PR_SEND: begin
					drv_n = 1'b1; bit_n = '0; scl_n = 1'b0; wait_full = 1'b0;
					step_n = iems_pkg::S_SEND_BIT;
				end
				PR_ACK: begin
					scl_n = 1'b0; drv_n = 1'b0; wait_full = 1'b1;
					step_n = iems_pkg::S_ACK_SCL1;
				end
				PR_NOACK: begin
					drv_n = 1'b1; scl_n = 1'b0; wait_full = 1'b0;
					step_n = iems_pkg::S_NOACK_SDA1;
				end
				PR_SACK: begin
					drv_n = 1'b1; scl_n = 1'b0; wait_full = 1'b0;
					step_n = iems_pkg::S_SACK_SDA0;
				end
				PR_READ: begin
					drv_n = 1'b0; scl_n = 1'b0; wait_full = 1'b0;
					step_n = iems_pkg::S_READ_LOOP;
				end
				PR_PWAIT: begin
					wait_full = 1'b1; step_n = iems_pkg::S_PWAIT_END;
				end
			endcase
		end

		if (wait_ld) begin
			wc_n = wait_full ? full_eff : half_eff;
		end
	end

	always_comb begin
		res_word.scl_level     = scl_n;
		res_word.sda_level     = sda_n;
		res_word.sda_drive     = drv_n;
		res_word.busy_res      = (phase_n != iems_pkg::PH_IDLE);
		res_word.done_res      = done;
		res_word.read_valid    = emit;
		res_word.read_value    = emit ? shift_q : 8'd0;
		res_word.read_position = emit ? bc_q[2:0] : 3'd0;
		res_word.nack_error    = nack_n;
		res_word.poll_seen     = poll_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q  <= iems_pkg::WAIT_W'(1);
			full_q  <= iems_pkg::WAIT_W'(2);
		end else if (cfg.valid) begin
			if (cfg.data.reg_index == iems_pkg::CFG_HALF) half_q <= cfg.data.wdata;
			if (cfg.data.reg_index == iems_pkg::CFG_FULL) full_q <= cfg.data.wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= iems_pkg::PH_IDLE;
			step_q  <= iems_pkg::S_STOP_END;
			wc_q    <= '0;
			bit_q   <= '0;
			bc_q    <= '0;
			shift_q <= '0;
			op_q    <= '0;
			addr_q  <= '0;
			data_q  <= '0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			drv_q   <= 1'b1;
			nack_q  <= 1'b0;
			poll_q  <= 1'b0;
			lnack_q <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_n;
			step_q  <= step_n;
			wc_q    <= wc_n;
			bit_q   <= bit_n;
			bc_q    <= bc_n;
			shift_q <= shift_n;
			op_q    <= op_n;
			addr_q  <= addr_n;
			data_q  <= data_n;
			scl_q   <= scl_n;
			sda_q   <= sda_n;
			drv_q   <= drv_n;
			nack_q  <= nack_n;
			poll_q  <= poll_n;
			lnack_q <= lnack_n;
		end
	end

	always_ff @(posedge clk) begin
		if (pb_we) pb_q[pb_wa] <= cmd.data.data_byte;
	end

	// two-entry result queue
	assign pop       = res.valid && res.ready;
	assign res.valid = (cnt_q != 2'd0);
	assign res.data  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (accept) fifo_q[wr_ptr_q] <= res_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (accept) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (accept && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !accept) cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule
`default_nettype wire
